// File: hw/rtl/ctli_pkg.sv
// Shared constants and types for the complex table linear interpolator.
// Used by complex_table_linear_interpolator_top; depends on nothing.
`default_nettype none

package ctli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int LANES       = 4;
    localparam int ROW_W       = VAL_W * LANES;
    localparam int IN_DATA_W   = 8 + 32 + ROW_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 9;
    localparam int DIV_STEPS   = 32;
    localparam int DCNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONST_MODE = 3'd0,
        CFG_EPER_RE    = 3'd1,
        CFG_EPER_IM    = 3'd2,
        CFG_MPER_RE    = 3'd3,
        CFG_MPER_IM    = 3'd4,
        CFG_ENTRY_CNT  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [VAL_W-1:0] RESET_ONE = 32'h0100_0000;

endpackage

`default_nettype wire

// File: hw/rtl/complex_table_linear_interpolator_top.sv
// Complex table linear interpolator: table memories, segment search and a
// shared multiply and restoring divide unit. Depends on ctli_pkg.
//
// Channel   Direction  Payload
// s_axis    in         tuser: opcode; tdata: entry_index, wavelength, 4 load values
// m_axis    out        tuser: status; tdata: eper_re, eper_im, mper_re, mper_im
// cfg       in         cfg_index selects the register, cfg_wdata is written
//
// A load, a constant-mode query or an empty-table query presents its result in
// the cycle after acceptance, a wavelength outside the outer keys after the S_LO
// and S_HI states. An interpolating query passes S_LO, S_HI, S_SCAN over the
// segments scanned, S_VLO and S_VHI, then per lane S_DIFF, S_MUL, the S_DIV
// steps of the shared 1-bit-per-cycle divider and S_ACC. One item is in flight
// at a time; the result holds until taken. Reset is synchronous, active low;
// table contents are undefined until loaded and need no clearing pass.
`default_nettype none

module complex_table_linear_interpolator_top
    import ctli_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // entry_index, wavelength, load_eper_re, load_eper_im, load_mper_re, load_mper_im
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // eper_re, eper_im, mper_re, mper_im
    output logic [ROW_W-1:0]           m_axis_tdata,
    // status
    output logic [1:0]                 m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LO   = 11'b000_0000_0010,
        S_HI   = 11'b000_0000_0100,
        S_SCAN = 11'b000_0000_1000,
        S_VLO  = 11'b000_0001_0000,
        S_VHI  = 11'b000_0010_0000,
        S_DIFF = 11'b000_0100_0000,
        S_MUL  = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_ACC  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    state_t             state_reg;
    logic               const_mode_reg;
    logic [ROW_W-1:0]   const_row_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    logic [VAL_W-1:0] wl_mem  [TABLE_DEPTH];
    logic [ROW_W-1:0] val_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] wl_rdata_reg;
    logic [ROW_W-1:0] val_rdata_reg;
    logic [ADDR_W-1:0] wl_raddr, val_raddr;

    logic [ADDR_W-1:0] idx_reg;
    logic [VAL_W-1:0]  wl_q_reg, key0_reg, lo_reg, dx_reg, dw_reg;
    logic [ROW_W-1:0]  va_reg, vb_reg, res_reg;
    status_t           status_reg;
    logic [1:0]        lane_reg;
    logic              neg_reg;
    logic [VAL_W-1:0]  mag_reg, rem_reg, low_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [CNT_W-1:0]  n_cnt;
    logic              in_acc, load_we;
    logic [VAL_W-1:0]  in_wl;
    logic [VAL_W-1:0]  lane_a, lane_b;
    logic signed [VAL_W:0] diff;
    logic [63:0]       prod;
    logic [VAL_W:0]    div_r;
    logic              div_ge;
    logic signed [VAL_W+1:0] acc_sum;
    logic [VAL_W-1:0]  acc_sat;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_wl   = s_axis_tdata[39:8];
    assign load_we = in_acc && (s_axis_tuser[0] == OP_LOAD)
                     && (32'(s_axis_tdata[7:0]) < 32'(TABLE_DEPTH));

    always_comb begin
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH)) begin
            n_cnt = CNT_W'(TABLE_DEPTH);
        end else begin
            n_cnt = CNT_W'(entry_count_reg);
        end
    end

    always_comb begin
        unique case (state_reg)
            S_IDLE:  wl_raddr = '0;
            S_LO:    wl_raddr = ADDR_W'(n_cnt - CNT_W'(1));
            S_HI:    wl_raddr = ADDR_W'(1);
            default: wl_raddr = idx_reg + ADDR_W'(2);
        endcase
        val_raddr = (state_reg == S_VLO) ? idx_reg + ADDR_W'(1) : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            wl_mem[ADDR_W'(s_axis_tdata[7:0])]  <= in_wl;
            val_mem[ADDR_W'(s_axis_tdata[7:0])] <= s_axis_tdata[IN_DATA_W-1:40];
        end
        wl_rdata_reg  <= wl_mem[wl_raddr];
        val_rdata_reg <= val_mem[val_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            const_mode_reg  <= 1'b1;
            const_row_reg   <= {32'd0, RESET_ONE, 32'd0, RESET_ONE};
            entry_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CONST_MODE: const_mode_reg              <= cfg_wdata[0];
                CFG_EPER_RE:    const_row_reg[31:0]         <= cfg_wdata;
                CFG_EPER_IM:    const_row_reg[63:32]        <= cfg_wdata;
                CFG_MPER_RE:    const_row_reg[95:64]        <= cfg_wdata;
                CFG_MPER_IM:    const_row_reg[127:96]       <= cfg_wdata;
                CFG_ENTRY_CNT:  entry_count_reg             <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign lane_a = va_reg[32'(lane_reg) * VAL_W +: VAL_W];
    assign lane_b = vb_reg[32'(lane_reg) * VAL_W +: VAL_W];
    assign diff   = $signed({lane_b[VAL_W-1], lane_b}) - $signed({lane_a[VAL_W-1], lane_a});
    assign prod   = 64'(mag_reg) * 64'(dx_reg);
    assign div_r  = {rem_reg, low_reg[VAL_W-1]};
    assign div_ge = div_r >= {1'b0, dw_reg};

    always_comb begin
        if (neg_reg) begin
            acc_sum = $signed({{2{lane_a[VAL_W-1]}}, lane_a}) - $signed({2'b00, low_reg});
        end else begin
            acc_sum = $signed({{2{lane_a[VAL_W-1]}}, lane_a}) + $signed({2'b00, low_reg});
        end
        if (acc_sum > $signed(34'sh0_7FFF_FFFF)) begin
            acc_sat = 32'h7FFF_FFFF;
        end else if (acc_sum < -$signed(34'sh0_8000_0000)) begin
            acc_sat = 32'h8000_0000;
        end else begin
            acc_sat = acc_sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        idx_reg    <= '0;
                        wl_q_reg   <= in_wl;
                        res_reg    <= '0;
                        status_reg <= ST_OK;
                        if (s_axis_tuser[0] == OP_LOAD) begin
                            state_reg <= S_OUT;
                        end else if (const_mode_reg) begin
                            res_reg   <= const_row_reg;
                            state_reg <= S_OUT;
                        end else if (n_cnt == '0) begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_LO;
                        end
                    end
                end
                S_LO: begin
                    key0_reg  <= wl_rdata_reg;
                    state_reg <= S_HI;
                end
                S_HI: begin
                    lo_reg <= key0_reg;
                    dw_reg <= '0;
                    if (wl_q_reg < key0_reg || wl_q_reg > wl_rdata_reg) begin
                        status_reg <= ST_OUTSIDE;
                        state_reg  <= S_OUT;
                    end else if (n_cnt == CNT_W'(1)) begin
                        state_reg <= S_VLO;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (lo_reg <= wl_q_reg && wl_q_reg <= wl_rdata_reg) begin
                        dx_reg    <= wl_q_reg - lo_reg;
                        dw_reg    <= wl_rdata_reg - lo_reg;
                        state_reg <= S_VLO;
                    end else if (32'(idx_reg) + 32'd2 >= 32'(n_cnt)) begin
                        status_reg <= ST_OUTSIDE;
                        state_reg  <= S_OUT;
                    end else begin
                        lo_reg  <= wl_rdata_reg;
                        idx_reg <= idx_reg + ADDR_W'(1);
                    end
                end
                S_VLO: begin
                    va_reg <= val_rdata_reg;
                    if (dw_reg == '0) begin
                        res_reg   <= val_rdata_reg;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_VHI;
                    end
                end
                S_VHI: begin
                    vb_reg    <= val_rdata_reg;
                    lane_reg  <= '0;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    neg_reg   <= diff[VAL_W];
                    mag_reg   <= diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    rem_reg   <= prod[63:32];
                    low_reg   <= prod[31:0];
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= div_ge ? VAL_W'(div_r - {1'b0, dw_reg}) : div_r[VAL_W-1:0];
                    low_reg  <= {low_reg[VAL_W-2:0], div_ge};
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    res_reg[32'(lane_reg) * VAL_W +: VAL_W] <= acc_sat;
                    if (lane_reg == 2'(LANES - 1)) begin
                        state_reg <= S_OUT;
                    end else begin
                        lane_reg  <= lane_reg + 2'd1;
                        state_reg <= S_DIFF;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = status_reg;

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error transaction carries nonzero values");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (32'(idx_reg) + 32'd2 <= 32'(n_cnt)))
        else $error("segment scan ran past the table end");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_axis_tuser[0] == OP_LOAD) |=> (m_axis_tvalid && m_axis_tuser == ST_OK))
        else $error("load did not complete in one cycle");
`endif

endmodule

`default_nettype wire
